>>> hw/rtl/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg: shared types and constants
// Payload structs, status codes and state encoding for the MST point set block.
// ----------------------------------------------------------------------------
package pmst_pkg;
	localparam int COORD_W = 24;
	localparam int IDX_W   = 6;
	localparam int KEY_W   = 50;
	localparam int SUM_W   = 40;

	localparam logic [KEY_W-1:0] KEY_INF = {KEY_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic [1:0] {
		ST_EDGE   = 2'd0,
		ST_SINGLE = 2'd1,
		ST_ERROR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		Z_MAIN   = 2'd0,
		Z_MED    = 2'd1,
		Z_BORDER = 2'd2
	} zone_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] end_low;
		logic [IDX_W-1:0] end_high;
		logic [SUM_W-1:0] total_length;
		logic             last_result;
	} result_t;

	typedef enum logic [3:0] {
		S_LOAD, S_INIT, S_SCAN, S_PICK, S_SQRT, S_UPD, S_EMIT, S_EDGE_RD, S_EDGE_OUT
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                      init;
		logic                      upd;
		logic [IDX_W-1:0]          pick;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		zone_t                     pzone;
		logic                      zone_en;
	} cell_ctl_t;

	function automatic zone_t zone_of(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		zone_t z;
		if (x > 0 || y > 0) z = Z_MAIN;
		else if (x < 0 && y < 0) z = Z_MED;
		else z = Z_BORDER;
		return z;
	endfunction
endpackage

>>> hw/rtl/prim_mst_point_set.sv
// ----------------------------------------------------------------------------
// prim_mst_point_set: minimum spanning tree of a loaded 2-D point set
// Points load into a row of vertex cells; Prim's algorithm runs on the row.
// ----------------------------------------------------------------------------
// Loading takes one point per cycle while not busy. After the last point each tree
// vertex goes through a minimum chain scan, pick and update plus the bit-serial
// square root; the edge results then follow through a read and an output state.
// A new set is taken only after the last result; busy is high until then.
// Reset clears control and flags and sets keys to all ones; results cannot be stalled.
module prim_mst_point_set
	import pmst_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  point_t  point,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	output logic    result_valid,
	output result_t result
);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int AW    = $clog2(MAX_POINTS);

	state_t           st_q, st_n;
	logic             zen_q;
	logic [CNT_W-1:0] cnt_q, n_q;
	logic [2:0]       zseen_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] step_q;
	logic [IDX_W-1:0] pick_q;
	logic [KEY_W-1:0] best_q;
	logic             accept;
	zone_t            inz;
	logic             sq_go, sq_done;
	logic [SUM_W-1:0] sq_root;
	logic [SUM_W:0]   sum_add;
	logic [AW-1:0]    rd_a;
	logic signed [COORD_W-1:0] rx, ry;
	cell_ctl_t        ctl;
	logic             shift;

	logic                 cv [MAX_POINTS+1];
	logic [KEY_W-1:0]     ck [MAX_POINTS+1];
	logic [IDX_W-1:0]     ci [MAX_POINTS+1];
	logic [IDX_W-1:0]     par [MAX_POINTS];
	logic [IDX_W-1:0]     par_sel;

	assign accept = start && !busy;
	assign busy   = (st_q != S_LOAD);
	assign inz    = zone_of(point.point_x, point.point_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zen_q <= 1'b1;
		else if (cfg_we) zen_q <= cfg_wdata;
	end

	// coordinate copy for reading the picked point
	pmst_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_xy (
		.clk(clk), .we(accept && cnt_q < CNT_W'(MAX_POINTS)), .waddr(cnt_q[AW-1:0]),
		.wdata({point.point_x, point.point_y}), .raddr(rd_a), .rdata({rx, ry}));

	assign rd_a = ci[MAX_POINTS][AW-1:0];

	assign shift = (st_q == S_SCAN);
	assign cv[0] = 1'b0;
	assign ck[0] = '0;
	assign ci[0] = '0;

	assign ctl.init    = (st_q == S_INIT);
	assign ctl.upd     = (st_q == S_UPD);
	assign ctl.pick    = pick_q;
	assign ctl.px      = rx;
	assign ctl.py      = ry;
	assign ctl.pzone   = zone_of(rx, ry);
	assign ctl.zone_en = zen_q;

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		pmst_cell #(.INDEX(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.load(accept && cnt_q == CNT_W'(g)),
			.lx(point.point_x), .ly(point.point_y),
			.active(CNT_W'(g) < n_q), .ctl(ctl), .shift(shift),
			.chain_vin(cv[g]), .chain_kin(ck[g]), .chain_iin(ci[g]),
			.chain_vout(cv[g+1]), .chain_kout(ck[g+1]), .chain_iout(ci[g+1]),
			.parent(par[g]));
	end

	assign par_sel = par[step_q[AW-1:0]];

	pmst_sqrt #(.FRAC(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(sq_go), .d2(ck[MAX_POINTS]),
		.done(sq_done), .root(sq_root));

	assign sum_add = {1'b0, sum_q} + {1'b0, sq_root};

	always_comb begin
		st_n  = st_q;
		sq_go = 1'b0;
		unique case (st_q)
			S_LOAD: if (accept && point.last_point) st_n = S_INIT;
			S_INIT: begin
				if (zen_q && zseen_q[1:0] == 2'b11 && !zseen_q[2]) st_n = S_EMIT;
				else if (n_q <= CNT_W'(1)) st_n = S_EMIT;
				else st_n = S_SCAN;
			end
			S_SCAN: if (step_q == CNT_W'(MAX_POINTS - 1)) st_n = S_PICK;
			S_PICK: begin
				if (!cv[MAX_POINTS]) st_n = S_EDGE_RD;
				else begin
					sq_go = (ck[MAX_POINTS] != KEY_INF);
					st_n  = S_SQRT;
				end
			end
			S_SQRT: if (sq_done || best_q == KEY_INF) st_n = S_UPD;
			S_UPD: st_n = S_SCAN;
			S_EMIT: st_n = S_LOAD;
			S_EDGE_RD: st_n = S_EDGE_OUT;
			S_EDGE_OUT: if (step_q == n_q - 1'b1) st_n = S_LOAD;
				else st_n = S_EDGE_RD;
			default: st_n = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_LOAD;
			cnt_q        <= '0;
			n_q          <= '0;
			zseen_q      <= '0;
			sum_q        <= '0;
			step_q       <= '0;
			pick_q       <= '0;
			best_q       <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			st_q         <= st_n;
			result_valid <= 1'b0;
			unique case (st_q)
				S_LOAD: if (accept) begin
					if (cnt_q < CNT_W'(MAX_POINTS))
						zseen_q <= zseen_q | (3'b001 << inz);
					if (point.last_point) begin
						n_q <= (cnt_q < CNT_W'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;
						cnt_q <= '0;
					end else if (cnt_q < CNT_W'(MAX_POINTS)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_INIT: begin
					sum_q  <= '0;
					step_q <= '0;
				end
				S_SCAN: step_q <= step_q + 1'b1;
				S_PICK: begin
					pick_q <= ci[MAX_POINTS];
					best_q <= ck[MAX_POINTS];
					step_q <= '0;
				end
				S_SQRT: if (sq_done)
					sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
				S_EMIT: begin
					result_valid <= 1'b1;
					result.status <= (n_q <= CNT_W'(1) && !(zen_q && zseen_q[1:0] == 2'b11
						&& !zseen_q[2])) ? ST_SINGLE : ST_ERROR;
					result.end_low      <= '0;
					result.end_high     <= '0;
					result.total_length <= '0;
					result.last_result  <= 1'b1;
					zseen_q             <= '0;
				end
				S_EDGE_RD: begin
					if (step_q == '0) step_q <= CNT_W'(1);
					zseen_q <= '0;
				end
				S_EDGE_OUT: begin
					result_valid  <= 1'b1;
					result.status <= ST_EDGE;
					if (par_sel < IDX_W'(step_q)) begin
						result.end_low  <= par_sel;
						result.end_high <= IDX_W'(step_q);
					end else begin
						result.end_low  <= IDX_W'(step_q);
						result.end_high <= par_sel;
					end
					result.last_result  <= (step_q == n_q - 1'b1);
					result.total_length <= (step_q == n_q - 1'b1) ? sum_q : '0;
					step_q <= step_q + 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

>>> hw/rtl/pmst_ram.sv
// ----------------------------------------------------------------------------
// pmst_ram: generic single-port write, registered-read RAM
// One write and one read address per cycle.
// ----------------------------------------------------------------------------
module pmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/pmst_cell.sv
// ----------------------------------------------------------------------------
// pmst_cell: one vertex of the tree
// Holds coordinates, key, parent and in-tree flag; computes the distance to
// the picked vertex from registered differences and joins the running minimum chain.
// ----------------------------------------------------------------------------
module pmst_cell
	import pmst_pkg::*;
#(
	parameter int unsigned INDEX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic signed [COORD_W-1:0] lx,
	input  logic signed [COORD_W-1:0] ly,
	input  logic                      active,
	input  cell_ctl_t                 ctl,
	input  logic                      shift,
	input  logic                      chain_vin,
	input  logic [KEY_W-1:0]          chain_kin,
	input  logic [IDX_W-1:0]          chain_iin,
	output logic                      chain_vout,
	output logic [KEY_W-1:0]          chain_kout,
	output logic [IDX_W-1:0]          chain_iout,
	output logic [IDX_W-1:0]          parent
);
	logic signed [COORD_W-1:0] x_q, y_q;
	logic [KEY_W-1:0]          key_q;
	logic [IDX_W-1:0]          par_q;
	logic                      tree_q;
	logic [COORD_W:0]          dx_s1, dy_s1;
	logic                      forbid_s1;
	logic [KEY_W-1:0]          d2;
	logic                      cand;
	logic                      cv_q;
	logic [KEY_W-1:0]          ck_q;
	logic [IDX_W-1:0]          ci_q;
	zone_t                     myz;
	logic signed [COORD_W:0]   ddx, ddy;

	assign myz = zone_of(x_q, y_q);
	assign ddx = {x_q[COORD_W-1], x_q} - {ctl.px[COORD_W-1], ctl.px};
	assign ddy = {y_q[COORD_W-1], y_q} - {ctl.py[COORD_W-1], ctl.py};

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= lx;
			y_q <= ly;
		end
		dx_s1 <= ddx[COORD_W] ? -ddx : ddx;
		dy_s1 <= ddy[COORD_W] ? -ddy : ddy;
		forbid_s1 <= ctl.zone_en && ((myz == Z_MAIN && ctl.pzone == Z_MED)
			|| (myz == Z_MED && ctl.pzone == Z_MAIN));
	end

	assign d2 = forbid_s1 ? KEY_INF
		: KEY_W'(dx_s1) * KEY_W'(dx_s1) + KEY_W'(dy_s1) * KEY_W'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_q <= 1'b0;
			key_q  <= KEY_INF;
			par_q  <= '0;
		end else if (ctl.init) begin
			tree_q <= 1'b0;
			key_q  <= (INDEX == 0) ? '0 : KEY_INF;
			par_q  <= '0;
		end else if (ctl.upd) begin
			if (ctl.pick == IDX_W'(INDEX)) tree_q <= 1'b1;
			else if (!tree_q && d2 < key_q) begin
				key_q <= d2;
				par_q <= ctl.pick;
			end
		end
	end

	assign cand = active && !tree_q;

	// minimum chain: shifts one cell per cycle in the scan state, lowest index wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= 1'b0;
			ck_q <= '0;
			ci_q <= '0;
		end else if (shift) begin
			if (cand && (!chain_vin || key_q < chain_kin)) begin
				cv_q <= 1'b1;
				ck_q <= key_q;
				ci_q <= IDX_W'(INDEX);
			end else begin
				cv_q <= chain_vin;
				ck_q <= chain_kin;
				ci_q <= chain_iin;
			end
		end
	end

	assign chain_vout = cv_q;
	assign chain_kout = ck_q;
	assign chain_iout = ci_q;
	assign parent     = par_q;
endmodule

>>> hw/rtl/pmst_sqrt.sv
// ----------------------------------------------------------------------------
// pmst_sqrt: restoring square root, one result bit per cycle
// Returns floor(sqrt(d2 * 4^FRAC)).
// ----------------------------------------------------------------------------
module pmst_sqrt
	import pmst_pkg::*;
#(
	parameter int FRAC = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [KEY_W-1:0] d2,
	output logic             done,
	output logic [SUM_W-1:0] root
);
	localparam int RW   = 25 + FRAC;
	localparam int OPW  = 2 * RW;
	localparam int CW   = $clog2(RW + 1);

	logic [OPW-1:0] op_q;
	logic [RW+1:0]  rem_q;
	logic [RW-1:0]  root_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [RW+1:0]  rem_n, trial;

	assign rem_n = {rem_q[RW-1:0], op_q[OPW-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			op_q   <= OPW'(d2) << (2 * FRAC);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q <= op_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign root = SUM_W'(root_q);
endmodule

>>> tb/tb_prim_mst_point_set.sv
// ----------------------------------------------------------------------------
// tb_prim_mst_point_set: self-checking bench for the MST point set block
// Loads point sets of random size and shape, predicts the tree edges and the
// fixed-point length in a scoreboard, and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_prim_mst_point_set;
	import pmst_pkg::*;

	localparam int NPTS = 64;
	localparam int FRAC = 8;
	localparam int WATCHDOG = 200000;

	class mst_scoreboard;
		logic signed [23:0] xs[NPTS];
		logic signed [23:0] ys[NPTS];
		int count;
		logic [2:0] zones;
		bit zone_en;
		result_t pending[$];
		int errors;

		function new();
			count = 0; zones = 0; zone_en = 1; errors = 0;
		endfunction

		function zone_t zone_class(logic signed [23:0] x, logic signed [23:0] y);
			zone_t z;
			if (x > 0 || y > 0) z = Z_MAIN;
			else if (x < 0 && y < 0) z = Z_MED;
			else z = Z_BORDER;
			return z;
		endfunction

		function logic [49:0] dist2(int a, int b);
			zone_t za, zb;
			logic [49:0] dx, dy;
			za = zone_class(xs[a], ys[a]);
			zb = zone_class(xs[b], ys[b]);
			if (zone_en && ((za == Z_MAIN && zb == Z_MED) || (za == Z_MED && zb == Z_MAIN)))
				return KEY_INF;
			dx = (xs[a] > xs[b]) ? 50'(longint'(xs[a]) - xs[b]) : 50'(longint'(xs[b]) - xs[a]);
			dy = (ys[a] > ys[b]) ? 50'(longint'(ys[a]) - ys[b]) : 50'(longint'(ys[b]) - ys[a]);
			return dx * dx + dy * dy;
		endfunction

		function logic [63:0] root_fixed(logic [63:0] d2);
			logic [63:0] r, rt, pair, trial;
			r = 0; rt = 0;
			for (int p = 24 + FRAC; p >= 0; p--) begin
				pair = (p >= FRAC) ? ((d2 >> (2 * (p - FRAC))) & 3) : 0;
				r = (r << 2) | pair;
				trial = (rt << 2) | 1;
				if (r >= trial) begin
					r = r - trial;
					rt = (rt << 1) | 1;
				end else begin
					rt = rt << 1;
				end
			end
			return rt;
		endfunction

		function void add_result(logic [1:0] st, int lo, int hi, logic [39:0] tot, bit fin);
			result_t r;
			r.status = st; r.end_low = 6'(lo); r.end_high = 6'(hi);
			r.total_length = tot; r.last_result = fin;
			pending.insert(pending.size(), r);
		endfunction

		function void note_point(point_t p);
			int n, pick;
			bit tree[NPTS];
			logic [49:0] key[NPTS];
			int par[NPTS];
			logic [49:0] best, d;
			logic [63:0] sum;
			if (count < NPTS) begin
				xs[count] = p.point_x; ys[count] = p.point_y;
				zones[zone_class(p.point_x, p.point_y)] = 1'b1;
				count++;
			end
			if (!p.last_point) return;
			n = count; count = 0;
			if (zone_en && zones[1:0] == 2'b11 && !zones[2]) begin
				zones = 0;
				add_result(ST_ERROR, 0, 0, 0, 1);
				return;
			end
			zones = 0;
			if (n <= 1) begin
				add_result(ST_SINGLE, 0, 0, 0, 1);
				return;
			end
			for (int i = 0; i < n; i++) begin
				tree[i] = 0; key[i] = KEY_INF; par[i] = 0;
			end
			key[0] = 0; sum = 0;
			for (int it = 0; it < n; it++) begin
				pick = n; best = 0;
				for (int i = 0; i < n; i++)
					if (!tree[i] && (pick == n || key[i] < best)) begin
						pick = i; best = key[i];
					end
				tree[pick] = 1;
				if (best != KEY_INF) begin
					sum += root_fixed(64'(best));
					if (sum > 64'(SUM_MAX)) sum = 64'(SUM_MAX);
				end
				for (int i = 0; i < n; i++)
					if (!tree[i]) begin
						d = dist2(pick, i);
						if (d < key[i]) begin
							key[i] = d; par[i] = pick;
						end
					end
			end
			for (int i = 1; i < n; i++)
				add_result(ST_EDGE, par[i] < i ? par[i] : i, par[i] < i ? i : par[i],
					i == n - 1 ? sum[39:0] : 40'd0, i == n - 1);
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.status !== exp_r.status || got.end_low !== exp_r.end_low ||
					got.end_high !== exp_r.end_high || got.total_length !== exp_r.total_length ||
					got.last_result !== exp_r.last_result) begin
				$display("%0t: expected st=%0d lo=%0d hi=%0d len=%0d last=%0d, actual st=%0d lo=%0d hi=%0d len=%0d last=%0d",
					$time, exp_r.status, exp_r.end_low, exp_r.end_high, exp_r.total_length,
					exp_r.last_result, got.status, got.end_low, got.end_high,
					got.total_length, got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, cfg_we, cfg_wdata, result_valid;
	point_t point;
	result_t result;
	mst_scoreboard sb;
	int idle_cycles;
	bit calm;

	prim_mst_point_set uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid), .result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
		if (arst_n && ((start && !busy) || result_valid)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("prim_mst_point_set: mismatch");
			$finish;
		end
	end

	task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, bit fin);
		point_t p;
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		p.point_x = x; p.point_y = y; p.last_point = fin;
		start <= 1;
		point <= p;
		do @(posedge clk); while (busy);
		sb.note_point(p);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_zone(bit v);
		drain();
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		sb.zone_en = v;
		cfg_we <= 0;
	endtask

	function automatic logic signed [23:0] rand_coord(int mode);
		logic signed [23:0] v;
		case (mode)
			0: v = 24'($urandom_range(0, 200) - 100);
			1: v = 24'($urandom);
			2: v = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			default: v = 24'($urandom_range(0, 6) - 3);
		endcase
		return v;
	endfunction

	task automatic random_set(int n);
		int mode;
		mode = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
	endtask

	initial begin
		int sent, n;
		sb = new();
		arst_n = 0; start = 0; cfg_we = 0; cfg_wdata = 0; point = '0;
		idle_cycles = 0; calm = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single point, then zone error (main + medical, no border)
		send_point(5, 5, 1);
		send_point(10, 3, 0);
		send_point(-4, -7, 1);
		// same with a border point: the set connects through the border point
		send_point(10, 3, 0);
		send_point(-4, -7, 0);
		send_point(0, -2, 1);
		// extremes, full-scale distances, ties
		send_point(24'sh7fffff, 24'sh7fffff, 0);
		send_point(24'sh800000, 24'sh800000, 0);
		send_point(24'sh7fffff, 24'sh800000, 0);
		send_point(24'sh800000, 24'sh7fffff, 0);
		send_point(0, 0, 1);
		send_point(1, 1, 0);
		send_point(1, 1, 0);
		send_point(1, 1, 1);
		set_zone(0);
		send_point(10, 3, 0);
		send_point(-4, -7, 1);
		send_point(24'sh7fffff, 24'sh7fffff, 0);
		send_point(24'sh800000, 24'sh800000, 1);
		set_zone(1);
		// overflow: 66 points, extras dropped
		for (int i = 0; i < 66; i++) send_point(24'(i), 24'(-i), i == 65);
		sent = 84;

		while (sent < 310) begin
			if ($urandom_range(0, 15) == 0) set_zone(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 10) == 0) drain();
			calm = sent > 260;
			n = $urandom_range(0, 20) == 0 ? $urandom_range(40, 64) : $urandom_range(1, 8);
			if (n > 310 - sent) n = 310 - sent;
			random_set(n);
			sent += n;
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("prim_mst_point_set: match");
		else $display("prim_mst_point_set: mismatch");
		$finish;
	end
endmodule
